### rtl/core/itlt_pkg.sv
// shared types, constants and lookup tables for the interval training lap timer
// no dependencies

package itlt_pkg;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpStop   = 2'd1,
    OpUpdate = 2'd2,
    OpTick   = 2'd3
  } op_e;

  // program codes
  localparam logic [2:0] Prog20x30   = 3'd0;
  localparam logic [2:0] Prog20x45   = 3'd1;
  localparam logic [2:0] Prog30x30   = 3'd2;
  localparam logic [2:0] Prog30x45   = 3'd3;
  localparam logic [2:0] ProgShuttle = 3'd4;

  // beep pattern loads
  localparam logic [2:0] BeepSingle = 3'd3;
  localparam logic [2:0] BeepDual   = 3'd5;
  localparam logic [2:0] BeepLong   = 3'd7;

  // lap lengths in tenths of a second and lap counts
  localparam logic [8:0] LapShort  = 9'd300;
  localparam logic [8:0] LapLong   = 9'd450;
  localparam logic [4:0] LapsFew   = 5'd20;
  localparam logic [4:0] LapsMany  = 5'd30;

  // shuttle test stages
  localparam int unsigned StageCount = 13;
  localparam int unsigned TableLen   = 13;
  localparam logic [5:0]  LastStage  = 6'(StageCount - 1);

  typedef struct packed {
    logic        run;
    logic [4:0]  lap_cnt;
    logic [8:0]  lap_period;
    logic [31:0] lap_start;
    logic [31:0] test_start;
    logic [2:0]  beep_cnt;
    logic        tone;
    logic        idle_ind;
    logic        run_ind;
  } state_t;

  // saturate a stage index to the last table entry
  function automatic logic [3:0] tbl_idx(input logic [4:0] i);
    tbl_idx = (i < 5'(TableLen)) ? i[3:0] : 4'(TableLen - 1);
  endfunction

  function automatic logic [8:0] stage_period(input logic [4:0] i);
    logic [3:0] k;
    k = tbl_idx(i);
    unique case (k)
      4'd0:    stage_period = 9'd90;
      4'd1:    stage_period = 9'd85;
      4'd2:    stage_period = 9'd80;
      4'd3:    stage_period = 9'd76;
      4'd4:    stage_period = 9'd72;
      4'd5:    stage_period = 9'd69;
      4'd6:    stage_period = 9'd65;
      4'd7:    stage_period = 9'd58;
      4'd8:    stage_period = 9'd55;
      4'd9:    stage_period = 9'd53;
      4'd10:   stage_period = 9'd51;
      4'd11:   stage_period = 9'd50;
      default: stage_period = 9'd48;
    endcase
  endfunction

  function automatic logic [13:0] stage_end(input logic [4:0] i);
    logic [3:0] k;
    k = tbl_idx(i);
    unique case (k)
      4'd0:    stage_end = 14'd1170;
      4'd1:    stage_end = 14'd1763;
      4'd2:    stage_end = 14'd2323;
      4'd3:    stage_end = 14'd2929;
      4'd4:    stage_end = 14'd3577;
      4'd5:    stage_end = 14'd4126;
      4'd6:    stage_end = 14'd4716;
      4'd7:    stage_end = 14'd5292;
      4'd8:    stage_end = 14'd5901;
      4'd9:    stage_end = 14'd6487;
      4'd10:   stage_end = 14'd7104;
      4'd11:   stage_end = 14'd7700;
      default: stage_end = 14'd8324;
    endcase
  endfunction

endpackage

### rtl/core/itlt_if.sv
// valid/ready channel interfaces for the lap timer event and result items
// depends on itlt_pkg

interface itlt_in_if;
  logic             valid;
  logic             ready;
  itlt_pkg::op_e    operation;
  logic [31:0]      now_time;

  modport source (output valid, output operation, output now_time, input ready);
  modport sink   (input valid, input operation, input now_time, output ready);
endinterface

interface itlt_out_if;
  logic       valid;
  logic       ready;
  logic       running;
  logic [4:0] lap_value;
  logic       buzzer_on;
  logic       idle_led;
  logic       run_led;

  modport source (output valid, output running, output lap_value, output buzzer_on,
                  output idle_led, output run_led, input ready);
  modport sink   (input valid, input running, input lap_value, input buzzer_on,
                  input idle_led, input run_led, output ready);
endinterface

### rtl/core/interval_training_lap_timer_unit.sv
// top level of the interval training lap timer: event register, state, result register
// depends on itlt_pkg, itlt_if and itlt_step

// Interval training lap timer. Each input item is one event (start, stop, time
// update, buzzer tick) with a time stamp in tenths of a second; each item gives
// exactly one result item holding the run flag, laps remaining (or the stage
// index in the shuttle program), buzzer tone and the two indicator LEDs as they
// stand after the event. The block takes one item per clock cycle while the output side
// keeps up: an accepted item sits in the event register, the state update and the result
// are formed from it combinationally and captured in the result register once that
// register is free or being drained; the result is then offered on the output side.
// The state update loop is combinational (one 32-bit add and compare for the lap end,
// one subtract and compare against the stage table). The output register holds
// a finished result while the event register keeps accepting, so a stalled
// consumer only stops input once both registers are full. The program register
// is written through cfg_we_i/cfg_wdata_i; codes above the shuttle program
// select the first fixed program. Write it only while no item is in flight.

module interval_training_lap_timer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  itlt_in_if.sink    in_ch,
  itlt_out_if.source out_ch
);
  import itlt_pkg::*;

  // program selection register
  logic [2:0] prog_q;

  // event register
  logic        ev_valid_q;
  op_e         ev_op_q;
  logic [31:0] ev_time_q;

  // timer state
  state_t st_q;
  state_t st_d;

  // result register
  logic       out_valid_q;
  logic       res_run_q;
  logic [4:0] res_lap_q;
  logic       res_tone_q;
  logic       res_idle_q;
  logic       res_runled_q;

  logic advance;
  logic in_fire;

  // event moves on whenever the result register is free or being drained
  assign advance  = ev_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !ev_valid_q || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= Prog20x30;
    end else if (cfg_we_i) begin
      prog_q <= (cfg_wdata_i > ProgShuttle) ? Prog20x30 : cfg_wdata_i;
    end
  end

  // event stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      ev_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_op_q   <= OpStart;
      ev_time_q <= '0;
    end else if (in_fire) begin
      ev_op_q   <= in_ch.operation;
      ev_time_q <= in_ch.now_time;
    end
  end

  itlt_step u_step (
    .st_i   (st_q),
    .prog_i (prog_q),
    .op_i   (ev_op_q),
    .time_i (ev_time_q),
    .st_o   (st_d)
  );

  // state commits in the same cycle the result is captured
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_run_q    <= st_d.run;
      res_lap_q    <= st_d.lap_cnt;
      res_tone_q   <= st_d.tone;
      res_idle_q   <= st_d.idle_ind;
      res_runled_q <= st_d.run_ind;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.running   = res_run_q;
  assign out_ch.lap_value = res_lap_q;
  assign out_ch.buzzer_on = res_tone_q;
  assign out_ch.idle_led  = res_idle_q;
  assign out_ch.run_led   = res_runled_q;

  // the two indicators never light together
  a_led_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.idle_ind && st_q.run_ind))
    else $error("idle and run indicators both set");

  // run flag and run indicator move together
  a_run_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.run == st_q.run_ind)
    else $error("run flag and run indicator differ");

  // tone is off once the beep pattern has run out
  a_tone_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.beep_cnt == 3'd0) |-> !st_q.tone)
    else $error("tone on with empty beep count");

  // a held event keeps its payload until it moves on
  a_ev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_q && !advance) |=> (ev_valid_q && $stable(ev_op_q) && $stable(ev_time_q)))
    else $error("stalled event changed");

  // state only changes when an event is committed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("state changed without an event");

endmodule

### rtl/core/itlt_step.sv
// next-state logic of the lap timer for one event item
// depends on itlt_pkg

module itlt_step (
  input  itlt_pkg::state_t st_i,
  input  logic [2:0]       prog_i,
  input  itlt_pkg::op_e    op_i,
  input  logic [31:0]      time_i,
  output itlt_pkg::state_t st_o
);
  import itlt_pkg::*;

  function automatic state_t do_stop(input state_t s);
    state_t r;
    r          = s;
    r.beep_cnt = BeepLong;
    r.tone     = 1'b1;
    r.idle_ind = 1'b1;
    r.run_ind  = 1'b0;
    r.run      = 1'b0;
    return r;
  endfunction

  logic [31:0] lap_end;
  logic        lap_done;
  logic [31:0] elapsed;
  logic        stage_done;
  logic [5:0]  next_stage;
  logic [4:0]  lap_dec;
  logic [2:0]  beep_dec;

  assign lap_end    = st_i.lap_start + {23'd0, st_i.lap_period};
  assign lap_done   = time_i > lap_end;
  assign elapsed    = time_i - st_i.test_start;
  assign stage_done = elapsed > {18'd0, stage_end(st_i.lap_cnt)};
  assign next_stage = {1'b0, st_i.lap_cnt} + 6'd1;
  assign lap_dec    = st_i.lap_cnt - 5'd1;
  assign beep_dec   = (st_i.beep_cnt == 3'd7) ? 3'd1 : st_i.beep_cnt - 3'd1;

  always_comb begin
    st_o = st_i;
    unique case (op_i)
      OpStart: begin
        st_o.beep_cnt  = BeepLong;
        st_o.tone      = 1'b1;
        st_o.run       = 1'b1;
        st_o.lap_start = time_i;
        st_o.run_ind   = 1'b1;
        st_o.idle_ind  = 1'b0;
        unique case (prog_i)
          Prog20x45: begin
            st_o.lap_cnt    = LapsFew;
            st_o.lap_period = LapLong;
          end
          Prog30x30: begin
            st_o.lap_cnt    = LapsMany;
            st_o.lap_period = LapShort;
          end
          Prog30x45: begin
            st_o.lap_cnt    = LapsMany;
            st_o.lap_period = LapLong;
          end
          ProgShuttle: begin
            st_o.lap_cnt    = 5'd0;
            st_o.lap_period = stage_period(5'd0);
            st_o.test_start = time_i;
          end
          default: begin
            st_o.lap_cnt    = LapsFew;
            st_o.lap_period = LapShort;
          end
        endcase
      end
      OpStop: st_o = do_stop(st_i);
      OpUpdate: begin
        if (st_i.run && lap_done) begin
          st_o.lap_start = lap_end;
          if (prog_i == ProgShuttle) begin
            if (stage_done) begin
              if (next_stage > LastStage) begin
                st_o = do_stop(st_o);
              end else begin
                st_o.lap_cnt    = next_stage[4:0];
                st_o.lap_period = stage_period(next_stage[4:0]);
                st_o.beep_cnt   = BeepDual;
                st_o.tone       = 1'b1;
              end
            end else begin
              st_o.beep_cnt = BeepSingle;
              st_o.tone     = 1'b1;
            end
          end else begin
            st_o.lap_cnt = lap_dec;
            if (lap_dec == 5'd0) begin
              st_o = do_stop(st_o);
            end else begin
              st_o.beep_cnt = lap_dec[0] ? BeepSingle : BeepDual;
              st_o.tone     = 1'b1;
            end
          end
        end
      end
      default: begin
        // buzzer tick
        if (st_i.beep_cnt != 3'd0) begin
          st_o.beep_cnt = beep_dec;
          st_o.tone     = beep_dec[0];
        end
      end
    endcase
  end

endmodule

### bench/interval_training_lap_timer_unit_tb.sv
// self-checking bench for the interval training lap timer unit
// depends on itlt_pkg, itlt_if and the rtl of interval_training_lap_timer_unit
`timescale 1ns / 1ps

module interval_training_lap_timer_unit_tb;
  import itlt_pkg::*;

  // one event item and one status item as they cross the channels
  typedef struct packed {
    op_e         op;
    logic [31:0] stamp;
  } timer_event_t;

  typedef struct packed {
    logic       running;
    logic [4:0] lap_value;
    logic       buzzer_on;
    logic       idle_led;
    logic       run_led;
  } timer_status_t;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TargetItems = 1550;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;

  itlt_in_if  ev_ch ();
  itlt_out_if st_ch ();

  interval_training_lap_timer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (ev_ch),
    .out_ch      (st_ch)
  );

  always #5 clk_i = ~clk_i;

  // shuttle stage tables: lap period per stage and stage end measured from test start
  logic [8:0]  shuttle_period [13] = '{90, 85, 80, 76, 72, 69, 65, 58, 55, 53, 51, 50, 48};
  logic [13:0] shuttle_end    [13] = '{1170, 1763, 2323, 2929, 3577, 4126, 4716, 5292,
                                       5901, 6487, 7104, 7700, 8324};

  // predicted timer state, mirrors the block after every accepted item
  logic [2:0]  p_program     = Prog20x30;
  logic        p_running     = 1'b0;
  logic [4:0]  p_laps        = '0;
  logic [8:0]  p_period      = '0;
  logic [31:0] p_lap_origin  = '0;
  logic [31:0] p_test_origin = '0;
  logic [2:0]  p_beeps       = '0;
  logic        p_tone        = 1'b0;
  logic        p_idle        = 1'b0;
  logic        p_runled      = 1'b0;

  timer_event_t  workout_q [$];   // events waiting for the driver
  timer_status_t status_q [$];    // statuses the block still owes
  timer_event_t  drive_item;
  timer_status_t seen_status;
  timer_status_t want_status;

  int unsigned events_queued = 0;
  int unsigned statuses_seen = 0;
  int unsigned status_errors = 0;
  logic [31:0] clock_cursor  = '0;

  logic        ev_taken   = 1'b0;
  logic        calm       = 1'b0;   // no random idling on either side
  logic        hold_armed = 1'b0;   // one long output stall
  logic        hold_done  = 1'b0;
  int unsigned hold_count = 0;

  function automatic int unsigned stage_slot(input logic [4:0] stage);
    return (stage < 5'd13) ? int'(stage) : 12;
  endfunction

  function automatic void sound_beep(input logic [2:0] pattern);
    p_beeps = pattern;
    p_tone  = 1'b1;
  endfunction

  function automatic void halt_timer();
    sound_beep(BeepLong);
    p_idle    = 1'b1;
    p_runled  = 1'b0;
    p_running = 1'b0;
  endfunction

  // apply one event to the predicted state and return the status it leaves
  function automatic timer_status_t timer_advance(input op_e op, input logic [31:0] stamp);
    logic [31:0] lap_end;
    logic [31:0] elapsed;
    case (op)
      OpStart: begin
        sound_beep(BeepLong);
        p_running    = 1'b1;
        p_lap_origin = stamp;
        p_runled     = 1'b1;
        p_idle       = 1'b0;
        case (p_program)
          Prog20x45: begin
            p_laps   = LapsFew;
            p_period = LapLong;
          end
          Prog30x30: begin
            p_laps   = LapsMany;
            p_period = LapShort;
          end
          Prog30x45: begin
            p_laps   = LapsMany;
            p_period = LapLong;
          end
          ProgShuttle: begin
            p_laps        = '0;
            p_period      = shuttle_period[0];
            p_test_origin = stamp;
          end
          default: begin
            p_laps   = LapsFew;
            p_period = LapShort;
          end
        endcase
      end
      OpStop: halt_timer();
      OpUpdate: begin
        lap_end = p_lap_origin + {23'd0, p_period};
        // one lap end at most per update, sums wrap in 32 bits
        if (p_running && stamp > lap_end) begin
          p_lap_origin = lap_end;
          if (p_program == ProgShuttle) begin
            elapsed = stamp - p_test_origin;
            if (elapsed > {18'd0, shuttle_end[stage_slot(p_laps)]}) begin
              // past the last stage the test is over
              if (p_laps >= 5'd12) begin
                halt_timer();
              end else begin
                p_laps   = p_laps + 5'd1;
                p_period = shuttle_period[stage_slot(p_laps)];
                sound_beep(BeepDual);
              end
            end else begin
              sound_beep(BeepSingle);
            end
          end else begin
            p_laps = p_laps - 5'd1;
            if (p_laps == 5'd0) halt_timer();
            else sound_beep(p_laps[0] ? BeepSingle : BeepDual);
          end
        end
      end
      default: begin
        // buzzer tick, long pattern skips from 7 straight to 1
        if (p_beeps != 3'd0) begin
          p_beeps = p_beeps - 3'd1;
          if (p_beeps == 3'd6) p_beeps = 3'd1;
          p_tone = p_beeps[0];
        end
      end
    endcase
    return '{running: p_running, lap_value: p_laps, buzzer_on: p_tone,
             idle_led: p_idle, run_led: p_runled};
  endfunction

  // event driver: presents a new item once the previous one was taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ev_ch.valid <= 1'b0;
    end else if (!ev_ch.valid || ev_taken) begin
      if (workout_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
        drive_item = workout_q.pop_front();
        ev_ch.valid     <= 1'b1;
        ev_ch.operation <= drive_item.op;
        ev_ch.now_time  <= drive_item.stamp;
      end else begin
        ev_ch.valid <= 1'b0;
      end
    end
  end

  // status sink: random back-pressure plus one long hold that fills the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      st_ch.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      st_ch.ready <= 1'b0;
      if (hold_count == HoldCycles - 1) hold_done <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      st_ch.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // monitor: predict on every accepted event, check every accepted status
  always @(posedge clk_i) begin
    ev_taken <= rst_ni && ev_ch.valid && ev_ch.ready;
    if (rst_ni && ev_ch.valid && ev_ch.ready) begin
      status_q.push_back(timer_advance(ev_ch.operation, ev_ch.now_time));
    end
    if (rst_ni && st_ch.valid && st_ch.ready) begin
      seen_status = '{running: st_ch.running, lap_value: st_ch.lap_value,
                      buzzer_on: st_ch.buzzer_on, idle_led: st_ch.idle_led,
                      run_led: st_ch.run_led};
      if (status_q.size() == 0) begin
        if (status_errors < 10) $display("status item %0d arrived with none expected",
                                         statuses_seen);
        status_errors++;
      end else begin
        want_status = status_q.pop_front();
        if (seen_status !== want_status) begin
          if (status_errors < 10) begin
            $display("status item %0d mismatch (expected/actual): running %0b/%0b",
                     statuses_seen, want_status.running, seen_status.running);
            $display("  lap %0d/%0d buzzer %0b/%0b idle %0b/%0b run %0b/%0b",
                     want_status.lap_value, seen_status.lap_value,
                     want_status.buzzer_on, seen_status.buzzer_on,
                     want_status.idle_led, seen_status.idle_led,
                     want_status.run_led, seen_status.run_led);
          end
          status_errors++;
        end
      end
      statuses_seen++;
    end
  end

  task automatic queue_event(input op_e op, input logic [31:0] stamp);
    workout_q.push_back('{op: op, stamp: stamp});
    events_queued++;
  endtask

  // every event gives one status, so equal counts mean nothing is in flight
  task automatic settle();
    while (statuses_seen < events_queued) @(negedge clk_i);
  endtask

  // program change only with the block empty
  task automatic write_program(input logic [2:0] code);
    settle();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    p_program = (code > ProgShuttle) ? Prog20x30 : code;
    @(posedge clk_i);
  endtask

  // a workout: updates walking forward near the lap length, ticks, some noise
  task automatic queue_workout(input logic [2:0] code, input bit with_start,
                               input int unsigned steps);
    int unsigned span;
    int unsigned pick;
    span = (code == ProgShuttle) ? 70 :
           ((code == Prog20x45 || code == Prog30x45) ? 450 : 300);
    if (with_start) queue_event(OpStart, clock_cursor);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        clock_cursor = clock_cursor + $urandom_range(span * 5 / 4, span * 3 / 4);
        queue_event(OpUpdate, clock_cursor);
      end else if (pick < 95) begin
        queue_event(OpTick, $urandom());
      end else begin
        case ($urandom_range(3))
          0: queue_event(OpStop, $urandom());
          1: begin
            clock_cursor = $urandom();
            queue_event(OpStart, clock_cursor);
          end
          2: queue_event(OpUpdate, $urandom());
          default: queue_event(OpTick, $urandom());
        endcase
      end
    end
  endtask

  initial begin
    int unsigned phase;
    logic [2:0]  code;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    ev_ch.valid     = 1'b0;
    ev_ch.operation = OpStart;
    ev_ch.now_time  = '0;
    st_ch.ready     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle events, wrap of the lap end, restart, both lap beeps
    write_program(Prog20x30);
    queue_event(OpTick, 32'h0000_0000);     // tick with nothing to sound
    queue_event(OpUpdate, 32'hFFFF_FFFF);   // ignored while stopped
    queue_event(OpStop, 32'h0000_0000);     // stop while stopped
    repeat (3) queue_event(OpTick, 32'hFFFF_FFFF);
    queue_event(OpStart, 32'hFFFF_FF00);    // lap end wraps past zero
    queue_event(OpUpdate, 32'hFFFF_FFFF);
    queue_event(OpStart, 32'h0000_0000);    // restart while running
    queue_event(OpUpdate, 32'd300);         // exactly at the lap end, no lap
    queue_event(OpUpdate, 32'd301);         // odd laps left, single beep
    repeat (3) queue_event(OpTick, 32'd0);
    queue_event(OpUpdate, 32'd602);         // even laps left, dual beep
    queue_event(OpTick, 32'd0);
    queue_event(OpStop, 32'd0);

    // directed shuttle: plain lap, stage change, far jump
    write_program(ProgShuttle);
    queue_event(OpStart, 32'd0);
    queue_event(OpUpdate, 32'd91);
    queue_event(OpUpdate, 32'd1300);
    queue_event(OpUpdate, 32'h8000_0000);
    queue_event(OpStop, 32'd0);

    // random workouts, each under its own program setting
    phase = 0;
    while (events_queued < TargetItems) begin
      if (phase < 8) code = 3'(phase);
      else if (phase % 3 == 0) code = ProgShuttle;
      else code = 3'($urandom_range(7));
      write_program(code);
      calm <= (phase == 5);
      case ($urandom_range(3))
        0: clock_cursor = '0;
        1: clock_cursor = 32'hFFFF_FFFF - $urandom_range(2000);
        default: clock_cursor = $urandom();
      endcase
      // some phases keep the old run going under the new program
      queue_workout(code, phase == 0 || $urandom_range(4) != 0,
                    (code == ProgShuttle) ? $urandom_range(260, 150) :
                                            $urandom_range(140, 40));
      if (phase == 2) hold_armed <= 1'b1;
      phase++;
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (status_errors == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
